// File: hw/rtl/fwdf_pkg.sv
// Shared types, character codes and rounding constants for the decimal formatter.
`default_nettype none

package fwdf_pkg;

  localparam int unsigned BIN_W      = 32;  // integer part of the magnitude
  localparam int unsigned INT_DIGITS = 10;  // decimal digits of a 32-bit integer
  localparam int unsigned BCD_W      = 4 * INT_DIGITS;
  localparam int unsigned CNT_W      = 5;   // counts the BIN_W shift steps
  localparam int unsigned CFG_W      = 6;   // widest configuration register
  localparam int unsigned FD_REG_W   = 5;

  localparam logic [6:0] CH_SPACE = 7'h20;
  localparam logic [6:0] CH_COMMA = 7'h2C;
  localparam logic [6:0] CH_MINUS = 7'h2D;
  localparam logic [6:0] CH_ZERO  = 7'h30;

  localparam logic REG_FIELD_WIDTH     = 1'b0;
  localparam logic REG_FRACTION_DIGITS = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROUND,
    ST_CONV,
    ST_LEN,
    ST_PAD,
    ST_SIGN,
    ST_INT,
    ST_COMMA,
    ST_FRAC
  } state_e;

  // converter status toward the sequencer
  typedef struct packed {
    logic             done;
    logic [BCD_W-1:0] digits;
  } bcd_rsp_t;

  // half a unit of the last printed digit in units of 2^-32, truncated
  function automatic logic [BIN_W-1:0] round_inc(input logic [FD_REG_W-1:0] fd);
    logic [BIN_W-1:0] r;
    unique case (fd)
      5'd0:    r = 32'd2147483648;
      5'd1:    r = 32'd214748364;
      5'd2:    r = 32'd21474836;
      5'd3:    r = 32'd2147483;
      5'd4:    r = 32'd214748;
      5'd5:    r = 32'd21474;
      5'd6:    r = 32'd2147;
      5'd7:    r = 32'd214;
      5'd8:    r = 32'd21;
      5'd9:    r = 32'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fwdf_bcd.sv
// Iterative binary to BCD converter, one shift-and-adjust step per cycle.
`default_nettype none

module fwdf_bcd (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [fwdf_pkg::BIN_W-1:0]  bin_i,
  output fwdf_pkg::bcd_rsp_t               rsp_o
);

  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [fwdf_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic [fwdf_pkg::BIN_W-1:0]     bin_q, bin_d;
  logic [fwdf_pkg::BCD_W-1:0]     bcd_q, bcd_d;
  logic [fwdf_pkg::BCD_W-1:0]     bcd_adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < fwdf_pkg::INT_DIGITS; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[fwdf_pkg::BCD_W-2:0], bin_q[fwdf_pkg::BIN_W-1]};
      bin_d = {bin_q[fwdf_pkg::BIN_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == fwdf_pkg::CNT_W'(fwdf_pkg::BIN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.digits = bcd_q;

endmodule

`default_nettype wire

// File: hw/rtl/fixed_width_decimal_formatter.sv
// Top level: formats a signed Q31.32 value as right-justified decimal text.
`default_nettype none

// One transaction is taken when start_i is high and busy_o is low; busy_o then
// stays high until the last character has gone out. The value is rounded, its
// integer part goes through a bit-serial BCD converter that shifts in one bit per
// step and then reports completion, the text is sized, and then one character
// leaves per cycle on char_code_o with out_valid_o high for that cycle only;
// last_o marks the final one. The receiver cannot stall the output: each
// character must be taken in the cycle it is shown. Configuration writes are
// meant for idle periods; an out-of-range width is saturated to MAX_WIDTH, and
// the fraction setting keeps its low five bits, saturated to MAX_FRACTION_DIGITS.
module fixed_width_decimal_formatter #(
  parameter int unsigned MAX_WIDTH           = 40,
  parameter int unsigned MAX_FRACTION_DIGITS = 16
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic                        cfg_idx_i,
  input  wire logic [fwdf_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  wire logic                        start_i,
  input  wire logic signed [63:0]          value_i,
  output logic                             busy_o,
  output logic                             out_valid_o,
  output logic [6:0]                       char_code_o,
  output logic                             last_o
);

  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned FW = $clog2(MAX_FRACTION_DIGITS + 1);

  fwdf_pkg::state_e state_q, state_d;

  logic [fwdf_pkg::CFG_W-1:0]    field_width_q;
  logic [fwdf_pkg::FD_REG_W-1:0] fraction_digits_q;

  logic                          neg_q;
  logic [63:0]                   mag_q, mag_d;
  logic [fwdf_pkg::BIN_W-1:0]    frac_q, frac_d;
  logic [WW-1:0]                 pad_q, pad_d;
  logic [3:0]                    idx_q, idx_d;
  logic [FW-1:0]                 fcnt_q, fcnt_d;

  logic [FW-1:0]                 fd_eff;
  logic [WW-1:0]                 width_eff;
  logic [63:0]                   sum;
  logic [35:0]                   frac_x10;
  logic [3:0]                    nint;
  logic [WW-1:0]                 len;
  logic [WW-1:0]                 pad_calc;
  logic [3:0]                    int_digit;
  logic                          conv_start;
  fwdf_pkg::bcd_rsp_t            conv_rsp;

  assign fd_eff = (fraction_digits_q > MAX_FRACTION_DIGITS) ? FW'(MAX_FRACTION_DIGITS)
                                                            : FW'(fraction_digits_q);
  assign width_eff = (field_width_q > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(field_width_q);

  assign sum        = mag_q + {32'd0, fwdf_pkg::round_inc(fwdf_pkg::FD_REG_W'(fd_eff))};
  assign conv_start = (state_q == fwdf_pkg::ST_ROUND);
  assign frac_x10   = {1'b0, frac_q, 3'b000} + {3'b000, frac_q, 1'b0};
  assign int_digit  = conv_rsp.digits[idx_q*4 +: 4];

  fwdf_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (conv_start),
    .bin_i   (sum[63:32]),
    .rsp_o   (conv_rsp)
  );

  // significant integer digits, at least one
  always_comb begin
    nint = 4'd1;
    for (int i = 1; i < fwdf_pkg::INT_DIGITS; i++) begin
      if (conv_rsp.digits[i*4 +: 4] != 4'd0) begin
        nint = 4'(i + 1);
      end
    end
  end

  always_comb begin
    len = WW'(neg_q) + WW'(nint);
    if (fd_eff != '0) begin
      len = len + WW'(fd_eff) + WW'(1);
    end
    pad_calc = (width_eff > len) ? (width_eff - len) : '0;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fwdf_pkg::ST_IDLE:  if (start_i) state_d = fwdf_pkg::ST_ROUND;
      fwdf_pkg::ST_ROUND: state_d = fwdf_pkg::ST_CONV;
      fwdf_pkg::ST_CONV:  if (conv_rsp.done) state_d = fwdf_pkg::ST_LEN;
      fwdf_pkg::ST_LEN: begin
        priority if (pad_calc != '0) state_d = fwdf_pkg::ST_PAD;
        else if (neg_q)              state_d = fwdf_pkg::ST_SIGN;
        else                         state_d = fwdf_pkg::ST_INT;
      end
      fwdf_pkg::ST_PAD: begin
        if (pad_q == WW'(1)) state_d = neg_q ? fwdf_pkg::ST_SIGN : fwdf_pkg::ST_INT;
      end
      fwdf_pkg::ST_SIGN:  state_d = fwdf_pkg::ST_INT;
      fwdf_pkg::ST_INT: begin
        if (idx_q == 4'd0) state_d = (fd_eff != '0) ? fwdf_pkg::ST_COMMA : fwdf_pkg::ST_IDLE;
      end
      fwdf_pkg::ST_COMMA: state_d = fwdf_pkg::ST_FRAC;
      fwdf_pkg::ST_FRAC:  if (fcnt_q == FW'(1)) state_d = fwdf_pkg::ST_IDLE;
      default:            state_d = fwdf_pkg::ST_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    mag_d  = mag_q;
    frac_d = frac_q;
    pad_d  = pad_q;
    idx_d  = idx_q;
    fcnt_d = fcnt_q;
    unique case (state_q)
      fwdf_pkg::ST_IDLE: begin
        // two's complement negate gives 2^63 exactly for the most negative input
        mag_d = value_i[63] ? (~value_i + 64'd1) : value_i;
      end
      fwdf_pkg::ST_ROUND: frac_d = sum[31:0];
      fwdf_pkg::ST_LEN: begin
        pad_d  = pad_calc;
        idx_d  = nint - 4'd1;
        fcnt_d = fd_eff;
      end
      fwdf_pkg::ST_PAD:   pad_d = pad_q - WW'(1);
      fwdf_pkg::ST_INT:   idx_d = idx_q - 4'd1;
      fwdf_pkg::ST_FRAC: begin
        frac_d = frac_x10[31:0];
        fcnt_d = fcnt_q - FW'(1);
      end
      default: ;
    endcase
  end

  // outputs
  always_comb begin
    busy_o      = (state_q != fwdf_pkg::ST_IDLE);
    out_valid_o = 1'b0;
    char_code_o = fwdf_pkg::CH_SPACE;
    last_o      = 1'b0;
    unique case (state_q)
      fwdf_pkg::ST_PAD: out_valid_o = 1'b1;
      fwdf_pkg::ST_SIGN: begin
        out_valid_o = 1'b1;
        char_code_o = fwdf_pkg::CH_MINUS;
      end
      fwdf_pkg::ST_INT: begin
        out_valid_o = 1'b1;
        char_code_o = fwdf_pkg::CH_ZERO + {3'b000, int_digit};
        last_o      = (idx_q == 4'd0) && (fd_eff == '0);
      end
      fwdf_pkg::ST_COMMA: begin
        out_valid_o = 1'b1;
        char_code_o = fwdf_pkg::CH_COMMA;
      end
      fwdf_pkg::ST_FRAC: begin
        out_valid_o = 1'b1;
        char_code_o = fwdf_pkg::CH_ZERO + {3'b000, frac_x10[35:32]};
        last_o      = (fcnt_q == FW'(1));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= fwdf_pkg::ST_IDLE;
      field_width_q     <= fwdf_pkg::CFG_W'(10);
      fraction_digits_q <= fwdf_pkg::FD_REG_W'(2);
      neg_q             <= 1'b0;
      pad_q             <= '0;
      idx_q             <= '0;
      fcnt_q            <= '0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      idx_q   <= idx_d;
      fcnt_q  <= fcnt_d;
      if (state_q == fwdf_pkg::ST_IDLE && start_i) begin
        neg_q <= value_i[63];
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          fwdf_pkg::REG_FIELD_WIDTH:     field_width_q     <= cfg_wdata_i;
          fwdf_pkg::REG_FRACTION_DIGITS: fraction_digits_q <= cfg_wdata_i[fwdf_pkg::FD_REG_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    frac_q <= frac_d;
  end

endmodule

`default_nettype wire

// File: tb/fwdf_checker.sv
// Checker for the decimal formatter: predicts the character stream and compares it.
`timescale 1ns / 100ps

module fwdf_checker
  import fwdf_pkg::*;
#(
  parameter int unsigned MAX_WIDTH           = 40,
  parameter int unsigned MAX_FRACTION_DIGITS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_idx_i,
  input  wire logic [CFG_W-1:0]  cfg_wdata_i,
  input  wire logic              start_i,
  input  wire logic              busy_i,
  input  wire logic [63:0]       value_i,
  input  wire logic              out_valid_i,
  input  wire logic [6:0]        char_code_i,
  input  wire logic              last_i,
  output int                     errors_o,
  output int                     pending_o
);

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } text_char_t;

  logic [5:0]         fmt_width;
  logic [4:0]         fmt_frac;
  text_char_t         expected_chars[$];

  // expands one value into the characters the block must emit
  function automatic void predict_text(input logic [63:0] raw);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [31:0] int_part;
    logic [31:0] frac_part;
    logic [31:0] half_ulp;
    logic [6:0]  body[$];
    logic [6:0]  int_chars[$];
    int          digits;
    int          width;
    int          pad;
    text_char_t  ch;

    digits = (fmt_frac > MAX_FRACTION_DIGITS) ? MAX_FRACTION_DIGITS : fmt_frac;
    width  = (fmt_width > MAX_WIDTH) ? MAX_WIDTH : fmt_width;

    half_ulp = 32'h8000_0000;
    for (int k = 0; k < digits; k++) half_ulp = half_ulp / 10;

    neg = raw[63];
    mag = neg ? (~raw + 64'd1) : raw;  // 2^63 still fits unsigned
    mag = mag + {32'd0, half_ulp};
    int_part  = mag[63:32];
    frac_part = mag[31:0];

    do begin
      int_chars.push_front(CH_ZERO + 7'(int_part % 10));
      int_part = int_part / 10;
    end while (int_part != 0);

    if (neg) body.push_back(CH_MINUS);
    foreach (int_chars[k]) body.push_back(int_chars[k]);
    if (digits > 0) begin
      body.push_back(CH_COMMA);
      repeat (digits) begin
        prod = {32'd0, frac_part} * 64'd10;
        body.push_back(CH_ZERO + 7'(prod[35:32]));
        frac_part = prod[31:0];
      end
    end

    pad = (width > body.size()) ? width - body.size() : 0;
    repeat (pad) begin
      ch.code = CH_SPACE;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    foreach (body[k]) begin
      ch.code = body[k];
      ch.last = (k == body.size() - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t exp_ch;
    if (!rst_ni) begin
      fmt_width = 6'd10;
      fmt_frac  = 5'd2;
      errors_o  = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FIELD_WIDTH) fmt_width = cfg_wdata_i[5:0];
        else fmt_frac = cfg_wdata_i[4:0];
      end
      if (start_i && !busy_i) predict_text(value_i);
      if (out_valid_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected character: expected none, actual code %02h last %0b",
                   $time, char_code_i, last_i);
          errors_o++;
        end else begin
          exp_ch = expected_chars.pop_front();
          if (char_code_i !== exp_ch.code) begin
            $display("%0t: char_code: expected %02h, actual %02h",
                     $time, exp_ch.code, char_code_i);
            errors_o++;
          end
          if (last_i !== exp_ch.last) begin
            $display("%0t: last: expected %0b, actual %0b", $time, exp_ch.last, last_i);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_chars.size();
  end

endmodule

// File: tb/testbench.sv
// Testbench top: clock, reset, stimulus and verdict for the decimal formatter.
`timescale 1ns / 100ps

module testbench;
  import fwdf_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              cfg_we_i    = 1'b0;
  logic              cfg_idx_i   = REG_FIELD_WIDTH;
  logic [CFG_W-1:0]  cfg_wdata_i = '0;
  logic              start_i     = 1'b0;
  logic [63:0]       value_i     = '0;
  logic              busy_o;
  logic              out_valid_o;
  logic [6:0]        char_code_o;
  logic              last_o;
  int                errors;
  int                pending;
  int unsigned       idle_cycles = 0;

  always #5 clk_i = ~clk_i;

  fixed_width_decimal_formatter uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .value_i     (value_i),
    .busy_o      (busy_o),
    .out_valid_o (out_valid_o),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

  fwdf_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .value_i     (value_i),
    .out_valid_i (out_valid_o),
    .char_code_i (char_code_o),
    .last_i      (last_o),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // watchdog: any transaction on either side restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || out_valid_o) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("fixed_width_decimal_formatter: mismatch");
        $finish;
      end
    end
  end

  // returns at the edge where the value was taken; start_i stays high
  task automatic send_value(input logic [63:0] v);
    int unsigned gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= v;
    do @(posedge clk_i); while (busy_o);
  endtask

  // stop sending and wait until every character has come out
  task automatic drain();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0 || busy_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic set_format(input logic [5:0] width, input logic [5:0] frac);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_FIELD_WIDTH;
    cfg_wdata_i <= width;
    @(posedge clk_i);
    cfg_idx_i   <= REG_FRACTION_DIGITS;
    cfg_wdata_i <= frac;  // bit 5 is don't-care for this register
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic logic [63:0] draw_value();
    logic [63:0] v;
    logic [31:0] ip;
    int unsigned kind;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: v = {$urandom, $urandom};
      3, 4, 5: v = {32'($urandom_range(0, 9999)), 32'($urandom)};
      6: v = {32'($urandom) >> $urandom_range(0, 31), ~(32'($urandom) >> $urandom_range(4, 31))};
      7: begin
        // all-nines integer part with a fraction close to one: rounding carry chain
        ip = 32'd9;
        repeat ($urandom_range(0, 8)) ip = ip * 10 + 9;
        v = {ip, ~(32'($urandom) >> $urandom_range(8, 31))};
      end
      8: begin
        case ($urandom_range(0, 3))
          0: v = 64'h0;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = 64'h8000_0000_0000_0000;
          default: v = 64'h1;
        endcase
      end
      default: v = {32'd0, 32'($urandom) >> $urandom_range(0, 31)};
    endcase
    if (kind >= 3 && kind != 8 && $urandom_range(0, 1)) v = ~v + 64'd1;
    return v;
  endfunction

  initial begin
    logic [63:0] reset_cfg_values[$];
    logic [5:0]  widths[$];
    logic [5:0]  fracs[$];

    reset_cfg_values = '{
      64'h0, 64'h1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
      64'h8000_0000_0000_0000, 64'h0000_0001_8000_0000, 64'hFFFF_FFFF_0000_0000,
      64'h0000_0000_FEB8_51EB, -64'h0000_007B_74BC_6A7F, 64'h0000_0000_FFFF_FFFF,
      64'h0000_03E7_FFBE_76C8
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset settings, then narrow/no-fraction, then the widest, then out-of-range
    foreach (reset_cfg_values[k]) send_value(reset_cfg_values[k]);
    drain();
    set_format(6'd0, 6'd0);
    send_value(64'h0);
    send_value(64'h0000_0000_8000_0000);
    send_value(-64'h0000_0000_6666_6666);  // negative that rounds to zero
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    drain();
    set_format(6'd40, 6'd16);
    send_value(64'h8000_0000_0000_0000);
    send_value(64'h0000_0000_0000_0001);
    drain();
    set_format(6'd63, 6'd31);
    send_value(64'hFFFF_FFFF_FFFF_FFFF);
    send_value(64'h7FFF_FFFF_FFFF_FFFF);
    drain();

    // random phases: extremes first, then random settings
    widths = '{6'd0, 6'd40, 6'd63, 6'd41, 6'd10, 6'd1};
    fracs  = '{6'd0, 6'd16, 6'd31, 6'd17, 6'd9, 6'd10};
    repeat (4) begin
      widths.push_back(6'($urandom_range(0, 63)));
      fracs.push_back(6'($urandom));
    end
    foreach (widths[p]) begin
      set_format(widths[p], fracs[p]);
      repeat (45) send_value(draw_value());
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("fixed_width_decimal_formatter: match");
    end else begin
      $display("fixed_width_decimal_formatter: mismatch");
    end
    $finish;
  end

endmodule
